// File: design/lpmd_pkg.sv
// Package for the length-prefixed message deframer.
// Types and constants shared by the result interface, front end, queue and output stage.
`default_nettype none

package lpmd_pkg;

  // Position within one length field (fields are 1 to 4 bytes long)
  localparam int unsigned IDX_W = 2;

  // Result queue between front end and output stage
  localparam int unsigned FIFO_AW    = 1;
  localparam int unsigned FIFO_DEPTH = 2 ** FIFO_AW;

  typedef enum logic [0:0] {
    OP_DATA    = 1'b0,
    OP_DISCARD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HLEN  = 2'd0,
    PH_PLEN  = 2'd1,
    PH_HBODY = 2'd2,
    PH_PBODY = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_out;
    kind_t      kind;
    logic       last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// File: design/lpmd_stream_if.sv
// Input byte stream channel of the deframer: valid/ready plus opcode and byte.
// Depends on nothing.
`default_nettype none

interface lpmd_stream_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] byte_in;

  modport source (output valid, output opcode, output byte_in, input ready);
  modport sink   (input valid, input opcode, input byte_in, output ready);
endinterface

`default_nettype wire

// File: design/lpmd_result_if.sv
// Result channel of the deframer: valid/ready plus data, kind and last mark.
// Depends on lpmd_pkg.
`default_nettype none

interface lpmd_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data_out;
  lpmd_pkg::kind_t   kind;
  logic              last;

  modport source (output valid, output data_out, output kind, output last, input ready);
  modport sink   (input valid, input data_out, input kind, input last, output ready);
endinterface

`default_nettype wire

// File: design/lpmd_front.sv
// Front end: takes stream beats, decodes the length fields and tags body bytes.
// Depends on lpmd_pkg.
`default_nettype none

module lpmd_front #(
  parameter int unsigned HEADER_LEN_BYTES  = 4,
  parameter int unsigned PAYLOAD_LEN_BYTES = 4
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     valid,
  output logic                    ready,
  input  wire                     opcode,
  input  wire  [7:0]              byte_in,
  input  lpmd_pkg::fifo_status_t  status,
  output logic                    push,
  output lpmd_pkg::result_t       result
);

  localparam int unsigned HLW = 8 * HEADER_LEN_BYTES;
  localparam int unsigned PLW = 8 * PAYLOAD_LEN_BYTES;
  localparam int unsigned RW  = (HLW > PLW) ? HLW : PLW;
  localparam int unsigned IW  = lpmd_pkg::IDX_W;

  lpmd_pkg::phase_t phase, phase_next;
  logic [IW-1:0]    idx, idx_next;
  logic [HLW-1:0]   header_length, header_length_next;
  logic [PLW-1:0]   payload_length, payload_length_next;
  logic [RW-1:0]    bytes_remaining, bytes_remaining_next;

  logic fire;
  logic in_progress;
  logic hlen_done;
  logic plen_done;
  logic section_end;

  assign ready       = !status.full;
  assign fire        = valid && ready;
  assign in_progress = (phase != lpmd_pkg::PH_HLEN) || (idx != '0);
  assign hlen_done   = (idx == IW'(HEADER_LEN_BYTES - 1));
  assign plen_done   = (idx == IW'(PAYLOAD_LEN_BYTES - 1));
  assign section_end = (bytes_remaining == RW'(1));

  // Length bytes land little-endian at the current field position
  always_comb begin
    header_length_next  = header_length;
    payload_length_next = payload_length;
    for (int k = 0; k < HEADER_LEN_BYTES; k++) begin
      if (idx == IW'(k)) begin
        header_length_next[8*k +: 8] = byte_in;
      end
    end
    for (int k = 0; k < PAYLOAD_LEN_BYTES; k++) begin
      if (idx == IW'(k)) begin
        payload_length_next[8*k +: 8] = byte_in;
      end
    end
  end

  // Next state
  always_comb begin
    phase_next           = phase;
    idx_next             = idx;
    bytes_remaining_next = bytes_remaining;
    if (fire) begin
      if (opcode == lpmd_pkg::OP_DISCARD) begin
        phase_next = lpmd_pkg::PH_HLEN;
        idx_next   = '0;
      end else begin
        case (phase)
          lpmd_pkg::PH_HLEN: begin
            if (hlen_done) begin
              idx_next   = '0;
              phase_next = lpmd_pkg::PH_PLEN;
            end else begin
              idx_next = idx + IW'(1);
            end
          end
          lpmd_pkg::PH_PLEN: begin
            if (plen_done) begin
              idx_next = '0;
              if (header_length != '0) begin
                phase_next           = lpmd_pkg::PH_HBODY;
                bytes_remaining_next = RW'(header_length);
              end else if (payload_length_next != '0) begin
                phase_next           = lpmd_pkg::PH_PBODY;
                bytes_remaining_next = RW'(payload_length_next);
              end else begin
                phase_next = lpmd_pkg::PH_HLEN;
              end
            end else begin
              idx_next = idx + IW'(1);
            end
          end
          lpmd_pkg::PH_HBODY: begin
            bytes_remaining_next = bytes_remaining - RW'(1);
            if (section_end) begin
              if (payload_length == '0) begin
                phase_next = lpmd_pkg::PH_HLEN;
              end else begin
                phase_next           = lpmd_pkg::PH_PBODY;
                bytes_remaining_next = RW'(payload_length);
              end
            end
          end
          lpmd_pkg::PH_PBODY: begin
            bytes_remaining_next = bytes_remaining - RW'(1);
            if (section_end) begin
              phase_next = lpmd_pkg::PH_HLEN;
            end
          end
          default: begin
            phase_next = lpmd_pkg::PH_HLEN;
          end
        endcase
      end
    end
  end

  // Result classification
  always_comb begin
    push            = 1'b0;
    result.data_out = 8'h00;
    result.kind     = lpmd_pkg::KIND_HEADER;
    result.last     = 1'b0;
    if (fire) begin
      if (opcode == lpmd_pkg::OP_DISCARD) begin
        if (in_progress) begin
          push        = 1'b1;
          result.kind = lpmd_pkg::KIND_ABORT;
          result.last = 1'b1;
        end
      end else begin
        case (phase)
          lpmd_pkg::PH_HLEN: begin
            push = 1'b0;
          end
          lpmd_pkg::PH_PLEN: begin
            if (plen_done && header_length == '0 && payload_length_next == '0) begin
              push        = 1'b1;
              result.kind = lpmd_pkg::KIND_EMPTY;
              result.last = 1'b1;
            end
          end
          lpmd_pkg::PH_HBODY: begin
            push            = 1'b1;
            result.data_out = byte_in;
            result.kind     = lpmd_pkg::KIND_HEADER;
            result.last     = section_end && (payload_length == '0);
          end
          lpmd_pkg::PH_PBODY: begin
            push            = 1'b1;
            result.data_out = byte_in;
            result.kind     = lpmd_pkg::KIND_PAYLOAD;
            result.last     = section_end;
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lpmd_pkg::PH_HLEN;
      idx   <= '0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  // Lengths and count are always loaded before they are read
  always_ff @(posedge clk) begin
    bytes_remaining <= bytes_remaining_next;
    if (fire && opcode == lpmd_pkg::OP_DATA) begin
      if (phase == lpmd_pkg::PH_HLEN) begin
        header_length <= header_length_next;
      end
      if (phase == lpmd_pkg::PH_PLEN) begin
        payload_length <= payload_length_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/lpmd_fifo.sv
// Short result queue between the front end and the output stage.
// Depends on lpmd_pkg.
`default_nettype none

module lpmd_fifo (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  lpmd_pkg::result_t       wr_data,
  input  wire                     pop,
  output lpmd_pkg::result_t       rd_data,
  output lpmd_pkg::fifo_status_t  status
);

  localparam int unsigned AW = lpmd_pkg::FIFO_AW;

  lpmd_pkg::result_t mem [lpmd_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;

  assign status.full  = (count == (AW+1)'(lpmd_pkg::FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/lpmd_back.sv
// Output stage: registers queued results and drives the result handshake.
// Depends on lpmd_pkg.
`default_nettype none

module lpmd_back (
  input  wire                     clk,
  input  wire                     rst,
  input  lpmd_pkg::fifo_status_t  status,
  input  lpmd_pkg::result_t       rd_data,
  output logic                    pop,
  output logic                    valid,
  input  wire                     ready,
  output lpmd_pkg::result_t       result
);

  // Refill when the register is empty or its beat leaves this cycle
  assign pop = !status.empty && (!valid || ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || ready) begin
      valid <= !status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= rd_data;
    end
  end

endmodule

`default_nettype wire

// File: design/length_prefixed_message_deframer_core.sv
// Length-prefixed message deframer. Takes one stream beat per clock unless its queue is full:
// each message is a little-endian header length (HEADER_LEN_BYTES bytes), a little-endian
// payload length (PAYLOAD_LEN_BYTES bytes), then the header and payload bodies. Body bytes
// come out tagged header or payload, last marking the final byte; an all-zero length pair
// gives one empty result, and a discard beat during a partial message gives one abort result.
// Sustained rate is one beat per clock in both directions while the result side keeps up; a
// result is written into a two-entry queue by the front-end decode when its beat is taken,
// then moved into the output register.
// stream.ready falls only when that queue is full, i.e. after the result side has stalled.
`default_nettype none

module length_prefixed_message_deframer_core #(
  parameter int unsigned HEADER_LEN_BYTES  = 4,
  parameter int unsigned PAYLOAD_LEN_BYTES = 4
) (
  input  wire            clk,
  input  wire            rst,
  lpmd_stream_if.sink    stream,
  lpmd_result_if.source  result
);

  lpmd_pkg::fifo_status_t status;
  lpmd_pkg::result_t      front_result;
  lpmd_pkg::result_t      queue_head;
  lpmd_pkg::result_t      out_result;
  logic                   push;
  logic                   pop;
  logic                   out_valid;

  lpmd_front #(
    .HEADER_LEN_BYTES  (HEADER_LEN_BYTES),
    .PAYLOAD_LEN_BYTES (PAYLOAD_LEN_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .valid   (stream.valid),
    .ready   (stream.ready),
    .opcode  (stream.opcode),
    .byte_in (stream.byte_in),
    .status  (status),
    .push    (push),
    .result  (front_result)
  );

  lpmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_result),
    .pop     (pop),
    .rd_data (queue_head),
    .status  (status)
  );

  lpmd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .status  (status),
    .rd_data (queue_head),
    .pop     (pop),
    .valid   (out_valid),
    .ready   (result.ready),
    .result  (out_result)
  );

  assign result.valid    = out_valid;
  assign result.data_out = out_result.data_out;
  assign result.kind     = out_result.kind;
  assign result.last     = out_result.last;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("result pushed into full queue");

  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    push |=> !status.empty)
    else $error("queue empty after push");

  a_marker_results: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.kind == lpmd_pkg::KIND_EMPTY ||
                  out_result.kind == lpmd_pkg::KIND_ABORT)
      |-> (out_result.data_out == 8'h00) && out_result.last)
    else $error("empty or abort result with data or without last");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: tb/length_prefixed_message_deframer_core_tb.sv
// Testbench for length_prefixed_message_deframer_core: drives framed byte streams with discards
// and checks each result beat against a behavioural deframer held here.
// Depends on lpmd_pkg, lpmd_stream_if and lpmd_result_if.

module length_prefixed_message_deframer_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HDR_FIELD_BYTES = 4;
  localparam int unsigned PAY_FIELD_BYTES = 4;
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    lpmd_pkg::op_t op;
    logic [7:0]    data;
  } beat_t;

  logic clk;
  logic rst;

  lpmd_stream_if stream ();
  lpmd_result_if result ();

  length_prefixed_message_deframer_core #(
    .HEADER_LEN_BYTES (HDR_FIELD_BYTES),
    .PAYLOAD_LEN_BYTES(PAY_FIELD_BYTES)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .stream(stream),
    .result(result)
  );

  beat_t             pending_beats[$];
  lpmd_pkg::result_t expected_results[$];
  int unsigned beats_queued;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned stall_cycles;

  // Deframer state as the block should hold it
  lpmd_pkg::phase_t frame_phase;
  int unsigned      field_pos;
  logic [31:0]      hdr_len;
  logic [31:0]      pay_len;
  logic [31:0]      body_left;

  function automatic void clear_frame();
    frame_phase = lpmd_pkg::PH_HLEN;
    field_pos   = 0;
    hdr_len     = '0;
    pay_len     = '0;
    body_left   = '0;
  endfunction

  function automatic void deframe_beat(input beat_t b, output bit emitted,
                                       output lpmd_pkg::result_t r);
    emitted = 1'b0;
    r = '0;
    if (b.op == lpmd_pkg::OP_DISCARD) begin
      if (frame_phase != lpmd_pkg::PH_HLEN || field_pos != 0) begin
        clear_frame();
        emitted = 1'b1;
        r.kind  = lpmd_pkg::KIND_ABORT;
        r.last  = 1'b1;
      end
      return;
    end
    case (frame_phase)
      lpmd_pkg::PH_HLEN: begin
        hdr_len[field_pos*8 +: 8] = b.data;
        field_pos++;
        if (field_pos == HDR_FIELD_BYTES) begin
          field_pos   = 0;
          frame_phase = lpmd_pkg::PH_PLEN;
        end
      end
      lpmd_pkg::PH_PLEN: begin
        pay_len[field_pos*8 +: 8] = b.data;
        field_pos++;
        if (field_pos == PAY_FIELD_BYTES) begin
          field_pos = 0;
          if (hdr_len == 0 && pay_len == 0) begin
            clear_frame();
            emitted = 1'b1;
            r.kind  = lpmd_pkg::KIND_EMPTY;
            r.last  = 1'b1;
          end else if (hdr_len != 0) begin
            frame_phase = lpmd_pkg::PH_HBODY;
            body_left   = hdr_len;
          end else begin
            frame_phase = lpmd_pkg::PH_PBODY;
            body_left   = pay_len;
          end
        end
      end
      lpmd_pkg::PH_HBODY: begin
        body_left  = body_left - 1;
        emitted    = 1'b1;
        r.data_out = b.data;
        r.kind     = lpmd_pkg::KIND_HEADER;
        if (body_left == 0) begin
          if (pay_len == 0) begin
            clear_frame();
            r.last = 1'b1;
          end else begin
            frame_phase = lpmd_pkg::PH_PBODY;
            body_left   = pay_len;
          end
        end
      end
      default: begin
        body_left  = body_left - 1;
        emitted    = 1'b1;
        r.data_out = b.data;
        r.kind     = lpmd_pkg::KIND_PAYLOAD;
        if (body_left == 0) begin
          clear_frame();
          r.last = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic queue_beat(input lpmd_pkg::op_t op, input logic [7:0] data);
    beat_t b;
    b.op   = op;
    b.data = data;
    pending_beats.insert(pending_beats.size(), b);
    beats_queued++;
  endtask

  // cut < 0 sends the whole message; otherwise cut bytes go out, then a discard if that cut it short
  task automatic queue_message(input logic [31:0] hlen, input logic [31:0] plen, input int cut);
    longint unsigned total;
    longint unsigned i;
    logic [7:0] v;
    total = HDR_FIELD_BYTES + PAY_FIELD_BYTES + longint'(hlen) + longint'(plen);
    i = 0;
    while (i < total && (cut < 0 || i < longint'(cut))) begin
      if (i < HDR_FIELD_BYTES)
        v = hlen[i*8 +: 8];
      else if (i < HDR_FIELD_BYTES + PAY_FIELD_BYTES)
        v = plen[(i - HDR_FIELD_BYTES)*8 +: 8];
      else
        v = 8'($urandom_range(255));
      queue_beat(lpmd_pkg::OP_DATA, v);
      i++;
    end
    if (cut >= 0 && longint'(cut) < total)
      queue_beat(lpmd_pkg::OP_DISCARD, 8'($urandom_range(255)));
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20)
      return 0;
    else if (r < 80)
      return $urandom_range(6, 1);
    else if (r < 97)
      return $urandom_range(40, 7);
    else
      return $urandom_range(300, 41);
  endfunction

  task automatic fill_random(input int unsigned upto);
    int unsigned r;
    int unsigned hl;
    int unsigned pl;
    int unsigned n;
    while (beats_queued < upto) begin
      r  = $urandom_range(99);
      hl = pick_len();
      pl = pick_len();
      if (r < 70) begin
        queue_message(hl, pl, -1);
      end else if (r < 82) begin
        // well-formed start, dropped part way through
        queue_message(hl, pl, $urandom_range(HDR_FIELD_BYTES + PAY_FIELD_BYTES + hl + pl - 1, 1));
      end else if (r < 90) begin
        // random lengths, usually huge: only a few bytes before the discard
        queue_message($urandom(), $urandom(), $urandom_range(12, 1));
      end else if (r < 95) begin
        queue_beat(lpmd_pkg::OP_DISCARD, 8'($urandom_range(255)));
      end else begin
        n = $urandom_range(3, 1);
        repeat (n) queue_beat(lpmd_pkg::OP_DATA, 8'($urandom_range(255)));
        queue_beat(lpmd_pkg::OP_DISCARD, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    stream.valid   = 1'b0;
    stream.opcode  = lpmd_pkg::OP_DATA;
    stream.byte_in = '0;
    result.ready   = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: holds a beat until taken, predicts its result on acceptance
  always @(posedge clk) begin : drive_beats
    beat_t             nxt;
    beat_t             taken;
    bit                emitted;
    lpmd_pkg::result_t r;
    if (rst) begin
      stream.valid <= 1'b0;
      clear_frame();
    end else begin
      if (stream.valid && stream.ready) begin
        taken.op   = lpmd_pkg::op_t'(stream.opcode);
        taken.data = stream.byte_in;
        deframe_beat(taken, emitted, r);
        if (emitted)
          expected_results.insert(expected_results.size(), r);
      end
      if (!stream.valid || stream.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          stream.valid   <= 1'b1;
          stream.opcode  <= nxt.op;
          stream.byte_in <= nxt.data;
        end else begin
          stream.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, checks each result beat
  always @(posedge clk) begin : check_results
    lpmd_pkg::result_t want;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: data %h kind %s last %b",
                     result.data_out, result.kind.name(), result.last);
        end else begin
          want = expected_results.pop_front();
          if (result.data_out !== want.data_out || result.kind !== want.kind ||
              result.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: exp data %h kind %s last %b, got data %h kind %s last %b",
                       want.data_out, want.kind.name(), want.last,
                       result.data_out, result.kind.name(), result.last);
          end
        end
      end
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (stream.valid && stream.ready) || (result.valid && result.ready) ||
        (pending_beats.size() == 0 && expected_results.size() == 0 && !stream.valid)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    beats_queued  = 0;
    mismatches    = 0;
    stall_cycles  = 0;
    send_idle_pct = 35;
    recv_idle_pct = 67;

    // empty message, discard while idle, maximal lengths cut short, header-only message
    queue_message(32'd0, 32'd0, -1);
    queue_beat(lpmd_pkg::OP_DISCARD, 8'hFF);
    queue_message(32'hFFFF_FFFF, 32'hFFFF_FFFF, HDR_FIELD_BYTES + PAY_FIELD_BYTES + 1);
    queue_message(32'd1, 32'd0, -1);
    fill_random(350);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    send_idle_pct = 67;
    recv_idle_pct = 35;
    fill_random(700);

    while (pending_beats.size() != 0) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(1050);

    while (pending_beats.size() != 0 || stream.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
